FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define TDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tdf assertion failed");

// Checked on every edge, reset included.
`define TDF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tdf assertion failed");

`endif

FILE: hdl/tdf_pkg.sv
// Shared types and constants of the trial-division factorizer.
package tdf_pkg;

  localparam int FIRST_DIVISOR = 2;

  typedef enum logic {
    KIND_TRIAL,
    KIND_DIRECT
  } job_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_START,
    B_WAIT,
    B_PUSH
  } back_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: hdl/tdf_interfaces.sv
// Valid/ready channel interfaces for numbers in and factors out.
interface tdf_num_if #(parameter int NUM_WIDTH = 31) ();
  logic                 valid;
  logic                 ready;
  logic [NUM_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface tdf_factor_if #(parameter int NUM_WIDTH = 31) ();
  logic                 valid;
  logic                 ready;
  logic [NUM_WIDTH-1:0] factor_value;
  logic                 last;
  logic                 truncated;

  modport source (output valid, output factor_value, output last, output truncated,
                  input ready);
  modport sink (input valid, input factor_value, input last, input truncated,
                output ready);
endinterface

FILE: hdl/tdf_front.sv
// Front end: accepts numbers and classifies them into direct or trial jobs.
module tdf_front #(
  parameter int NUM_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  tdf_num_if.sink              numbers,
  output logic                 push,
  output logic [NUM_WIDTH:0]   push_data,
  input  logic                 full
);
  import tdf_pkg::*;

  logic                 hold_vld;
  job_kind_t            hold_kind;
  logic [NUM_WIDTH-1:0] hold_num;
  logic                 take;

  assign push          = hold_vld;
  assign push_data     = {hold_kind, hold_num};
  assign numbers.ready = !hold_vld || !full;
  assign take          = numbers.valid && numbers.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (take) begin
      hold_vld <= 1'b1;
    end else if (hold_vld && !full) begin
      hold_vld <= 1'b0;
    end
  end

  // zero and one are emitted as they are
  always_ff @(posedge clk) begin
    if (take) begin
      hold_num  <= numbers.number;
      hold_kind <= (numbers.number <= NUM_WIDTH'(1)) ? KIND_DIRECT : KIND_TRIAL;
    end
  end

endmodule

FILE: hdl/tdf_fifo.sv
// Short job queue between front and back.
module tdf_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             avail
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign avail    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/tdf_divider.sv
// Restoring divider, one quotient bit per cycle.
module tdf_divider #(
  parameter int NUM_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tdf_pkg::div_ctl_t    ctl,
  output tdf_pkg::div_sts_t    sts,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [NUM_WIDTH-1:0] divisor,
  output logic [NUM_WIDTH-1:0] quotient,
  output logic [NUM_WIDTH-1:0] remainder
);
  import tdf_pkg::*;

  localparam int CNTW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] acc;
  logic [NUM_WIDTH-1:0] qreg;
  logic [NUM_WIDTH-1:0] dsr;
  logic [CNTW-1:0]      cnt;
  logic                 busy;
  logic                 done;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic                 fits;

  assign trial     = {acc, qreg[NUM_WIDTH-1]};
  assign diff      = trial - {1'b0, dsr};
  assign fits      = (trial >= {1'b0, dsr});
  assign quotient  = qreg;
  assign remainder = acc;
  assign sts.busy  = busy;
  assign sts.done  = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc  <= '0;
      qreg <= dividend;
      dsr  <= divisor;
      cnt  <= CNTW'(NUM_WIDTH);
    end else if (busy) begin
      acc  <= fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
      qreg <= {qreg[NUM_WIDTH-2:0], fits};
      cnt  <= cnt - CNTW'(1);
    end
  end

endmodule

FILE: hdl/tdf_back.sv
// Back end: trial-division sequencer and output register.
module tdf_back #(
  parameter int NUM_WIDTH    = 31,
  parameter int FACTOR_LIMIT = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_avail,
  input  logic [NUM_WIDTH:0]   job_data,
  output logic                 job_pop,
  tdf_factor_if.source         factors
);
  import tdf_pkg::*;

  localparam int CW = $clog2(FACTOR_LIMIT + 1);

  back_state_t          state, state_next;
  logic [NUM_WIDTH-1:0] rem, rem_next;
  logic [NUM_WIDTH-1:0] dvs, dvs_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic [NUM_WIDTH-1:0] pend_value, pend_value_next;
  logic                 pend_last, pend_last_next;
  logic                 pend_trunc, pend_trunc_next;
  logic                 pend_done, pend_done_next;
  logic                 out_vld, out_vld_next;
  logic [NUM_WIDTH-1:0] out_value, out_value_next;
  logic                 out_last, out_last_next;
  logic                 out_trunc, out_trunc_next;

  div_ctl_t             div_ctl;
  div_sts_t             div_sts;
  logic [NUM_WIDTH-1:0] quo;
  logic [NUM_WIDTH-1:0] mod;
  logic [CW-1:0]        cnt_inc;
  logic                 at_limit;
  logic                 slot_free;
  job_kind_t            job_kind;

  tdf_divider #(.NUM_WIDTH(NUM_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .sts       (div_sts),
    .dividend  (rem),
    .divisor   (dvs),
    .quotient  (quo),
    .remainder (mod)
  );

  assign job_kind  = job_kind_t'(job_data[NUM_WIDTH]);
  assign cnt_inc   = cnt + CW'(1);
  assign at_limit  = (cnt_inc == CW'(FACTOR_LIMIT));
  assign slot_free = !out_vld || factors.ready;

  assign factors.valid        = out_vld;
  assign factors.factor_value = out_value;
  assign factors.last         = out_last;
  assign factors.truncated    = out_trunc;

  always_comb begin
    state_next      = state;
    rem_next        = rem;
    dvs_next        = dvs;
    cnt_next        = cnt;
    pend_value_next = pend_value;
    pend_last_next  = pend_last;
    pend_trunc_next = pend_trunc;
    pend_done_next  = pend_done;
    out_vld_next    = out_vld && !factors.ready;
    out_value_next  = out_value;
    out_last_next   = out_last;
    out_trunc_next  = out_trunc;
    job_pop         = 1'b0;
    div_ctl.start   = 1'b0;
    case (state)
      B_IDLE: begin
        if (job_avail) begin
          job_pop  = 1'b1;
          rem_next = job_data[NUM_WIDTH-1:0];
          dvs_next = NUM_WIDTH'(FIRST_DIVISOR);
          cnt_next = '0;
          if (job_kind == KIND_DIRECT) begin
            pend_value_next = job_data[NUM_WIDTH-1:0];
            pend_last_next  = 1'b1;
            pend_trunc_next = 1'b0;
            pend_done_next  = 1'b1;
            state_next      = B_PUSH;
          end else begin
            state_next = B_START;
          end
        end
      end
      B_START: begin
        if (!div_sts.busy) begin
          div_ctl.start = 1'b1;
          state_next    = B_WAIT;
        end
      end
      B_WAIT: begin
        if (div_sts.done) begin
          if (mod == '0) begin
            // divisor found; a cofactor above one after the limit means truncation
            pend_value_next = dvs;
            pend_last_next  = (quo == NUM_WIDTH'(1)) || at_limit;
            pend_trunc_next = at_limit && (quo > NUM_WIDTH'(1));
            pend_done_next  = (quo == NUM_WIDTH'(1)) || at_limit;
            rem_next        = quo;
            cnt_next        = cnt_inc;
            state_next      = B_PUSH;
          end else if (dvs > quo) begin
            // divisor squared exceeds cofactor: cofactor is prime
            pend_value_next = rem;
            pend_last_next  = 1'b1;
            pend_trunc_next = 1'b0;
            pend_done_next  = 1'b1;
            state_next      = B_PUSH;
          end else begin
            dvs_next   = (dvs == NUM_WIDTH'(FIRST_DIVISOR)) ? NUM_WIDTH'(3)
                                                             : dvs + NUM_WIDTH'(2);
            state_next = B_START;
          end
        end
      end
      B_PUSH: begin
        if (slot_free) begin
          out_vld_next   = 1'b1;
          out_value_next = pend_value;
          out_last_next  = pend_last;
          out_trunc_next = pend_trunc;
          state_next     = pend_done ? B_IDLE : B_START;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      out_vld <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    rem        <= rem_next;
    dvs        <= dvs_next;
    cnt        <= cnt_next;
    pend_value <= pend_value_next;
    pend_last  <= pend_last_next;
    pend_trunc <= pend_trunc_next;
    pend_done  <= pend_done_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
    out_trunc  <= out_trunc_next;
  end

endmodule

FILE: hdl/trial_division_factorizer_unit.sv
// Top level of the trial-division prime factorizer.
//
// numbers: one word per integer to factor (NUM_WIDTH bits, unsigned).
// factors: one word per prime factor, ascending, repeated per multiplicity;
//   last marks the final factor of a number, truncated on that word says
//   factors beyond FACTOR_LIMIT were dropped. Zero and one come out as is.
// A front stage registers and classifies each number and hands it to a
// two-entry job queue; the back sequencer drains the queue one number at a
// time, so up to three numbers can be taken while the back end is busy.
// Each trial division runs on a restoring divider, with issue and decision
// around it. A number needs one trial per divisor up to the square root of
// its cofactor plus one per factor found; direct numbers need no trial.
// Reset is synchronous: it empties the queue, drops any work in flight and
// the pending output word. If factors stalls, the output register holds its
// word and the sequencer waits before its next push; input keeps filling the
// queue until it is full.
module trial_division_factorizer_unit #(
  parameter int NUM_WIDTH    = 31,
  parameter int FACTOR_LIMIT = 10
) (
  input  logic         clk,
  input  logic         rst,
  tdf_num_if.sink      numbers,
  tdf_factor_if.source factors
);
  localparam int JOB_W = NUM_WIDTH + 1;

  logic             push;
  logic [JOB_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic [JOB_W-1:0] pop_data;
  logic             avail;

  tdf_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .numbers   (numbers),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  tdf_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .avail     (avail)
  );

  tdf_back #(.NUM_WIDTH(NUM_WIDTH), .FACTOR_LIMIT(FACTOR_LIMIT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (avail),
    .job_data  (pop_data),
    .job_pop   (pop),
    .factors   (factors)
  );

endmodule

FILE: hdl/tdf_checker.sv
// Port-level checker for the factorizer, bound to the top level.
`include "assert_macros.svh"

module tdf_checker #(
  parameter int NUM_WIDTH = 31
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [NUM_WIDTH-1:0] out_value,
  input logic                 out_last,
  input logic                 out_trunc
);

  `TDF_ASSERT_ALWAYS(a_reset_clean, rst |=> (in_ready && !out_valid))
  `TDF_ASSERT(a_valid_holds, (out_valid && !out_ready) |=> out_valid)
  `TDF_ASSERT(a_trunc_on_last, (out_valid && out_trunc) |-> out_last)
  `TDF_ASSERT(a_inner_is_prime, (out_valid && !out_last) |-> (out_value >= NUM_WIDTH'(2)))

endmodule

bind trial_division_factorizer_unit tdf_checker #(.NUM_WIDTH(NUM_WIDTH)) u_tdf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (numbers.ready),
  .out_valid (factors.valid),
  .out_ready (factors.ready),
  .out_value (factors.factor_value),
  .out_last  (factors.last),
  .out_trunc (factors.truncated)
);

FILE: tb/tb.sv
// Testbench for trial_division_factorizer_unit: predicted factor words checked in order.
`timescale 1ns / 100ps

module tb;

  localparam int NUM_WIDTH    = 31;
  localparam int FACTOR_LIMIT = 10;
  localparam int unsigned RUN_LIMIT   = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam longint unsigned NUM_MAX = (64'd1 << NUM_WIDTH) - 1;

  typedef struct packed {
    logic [NUM_WIDTH-1:0] factor_value;
    logic                 last;
    logic                 truncated;
  } factor_word_t;

  class factor_ledger;
    factor_word_t expected_factors[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endfunction

    // Trial division: 2, then odd divisors while d*d <= cofactor.
    function void note_number(logic [NUM_WIDTH-1:0] n);
      factor_word_t     w;
      longint unsigned  cofactor;
      longint unsigned  d;
      int               count;
      bit               full;
      cofactor = n;
      d = 2;
      count = 0;
      full = 0;
      w = '0;
      if (n <= 1) begin
        w.factor_value = n;
        expected_factors.push_back(w);
      end else begin
        while (!full && d <= cofactor / d) begin
          while (cofactor % d == 0) begin
            if (count == FACTOR_LIMIT) begin
              full = 1;
              break;
            end
            w.factor_value = d[NUM_WIDTH-1:0];
            expected_factors.push_back(w);
            count++;
            cofactor = cofactor / d;
          end
          if (full)
            break;
          d = (d == 2) ? 3 : d + 2;
        end
        if (!full && cofactor > 1) begin
          if (count == FACTOR_LIMIT) begin
            full = 1;
          end else begin
            w.factor_value = cofactor[NUM_WIDTH-1:0];
            expected_factors.push_back(w);
          end
        end
      end
      w = expected_factors.pop_back();
      w.last = 1'b1;
      w.truncated = full;
      expected_factors.push_back(w);
    endfunction

    function void check_factor(logic [NUM_WIDTH-1:0] fv, logic lst, logic trunc);
      factor_word_t want;
      if (expected_factors.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none actual factor %0d last %0b truncated %0b",
                 $time, fv, lst, trunc);
        return;
      end
      want = expected_factors.pop_front();
      if (want.factor_value !== fv)
        flag("factor_value", want.factor_value, fv);
      if (want.last !== lst)
        flag("last", want.last, lst);
      if (want.truncated !== trunc)
        flag("truncated", want.truncated, trunc);
    endfunction
  endclass

  logic clk;
  logic rst;

  tdf_num_if #(.NUM_WIDTH(NUM_WIDTH))    num_ch ();
  tdf_factor_if #(.NUM_WIDTH(NUM_WIDTH)) factor_ch ();

  trial_division_factorizer_unit #(
    .NUM_WIDTH    (NUM_WIDTH),
    .FACTOR_LIMIT (FACTOR_LIMIT)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .numbers (num_ch.sink),
    .factors (factor_ch.source)
  );

  factor_ledger ledger = new();

  int unsigned src_idle_pct = 24;
  int unsigned sink_idle_pct = 87;
  int unsigned cycle_count = 0;
  bit          hold_active = 0;
  event        hold_ev;
  int unsigned small_primes [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 97};

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    num_ch.valid = 1'b0;
    num_ch.number = '0;
    factor_ch.ready = 1'b0;
  end

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin
    factor_ch.ready <= !hold_active && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (num_ch.valid && num_ch.ready)
        ledger.note_number(num_ch.number);
      if (factor_ch.valid && factor_ch.ready)
        ledger.check_factor(factor_ch.factor_value, factor_ch.last, factor_ch.truncated);
    end
  end

  task automatic send_number(input logic [NUM_WIDTH-1:0] n);
    while ($urandom_range(99) < src_idle_pct) begin
      num_ch.valid <= 1'b0;
      @(posedge clk);
    end
    num_ch.valid <= 1'b1;
    num_ch.number <= n;
    @(posedge clk);
    while (!num_ch.ready)
      @(posedge clk);
  endtask

  // Mostly smooth numbers with random content (fast, often truncated),
  // some plain 16-bit values and some zero/one/two/three.
  task automatic send_random(input int unsigned count);
    longint unsigned n;
    int unsigned     f;
    int unsigned     pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        n = $urandom_range(0, 3);
      end else if (pick < 25) begin
        n = $urandom_range(0, 65535);
      end else begin
        n = $urandom_range(1, 4095);
        repeat ($urandom_range(0, 14)) begin
          f = small_primes[$urandom_range(0, 11)];
          if (n * f <= NUM_MAX)
            n = n * f;
        end
      end
      send_number(n[NUM_WIDTH-1:0]);
    end
  endtask

  // first edge lets the monitor log a word taken on the current edge
  task automatic wait_all_factors();
    @(posedge clk);
    while (ledger.expected_factors.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, one, small primes, limit edges, field extremes
    send_number(31'd0);
    send_number(31'd1);
    send_number(31'd2);
    send_number(31'd3);
    send_number(31'd4);
    send_number(31'd9);
    send_number(31'd49);
    send_number(31'd1024);
    send_number(31'd2048);
    send_number(31'd3072);
    send_number(31'd59049);
    send_number(31'd177147);
    send_number(31'd9409);
    send_number(31'd65537);
    send_number(31'd223092870);
    send_number(31'd1162261467);
    send_number(31'h4000_0000);
    send_number(31'h3FFF_FFFF);
    send_number(31'h5555_5555);
    send_number(31'h7FFF_FFFE);
    send_number(31'h7FFF_FFFF);

    send_random(25);

    // sender pause until the block has drained
    num_ch.valid <= 1'b0;
    wait_all_factors();
    src_idle_pct = 87;
    sink_idle_pct = 24;
    send_random(30);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    -> hold_ev;
    send_random(25);

    num_ch.valid <= 1'b0;
    wait_all_factors();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.expected_factors.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
